>>> rtl/lba_pkg.sv
// Shared sizes, codes and controller/datapath bundles of the linked block allocator.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package lba_pkg;

  localparam int BLOCK_COUNT = 1024;
  localparam int FILE_SLOTS  = 128;

  localparam int BLK_W   = $clog2(BLOCK_COUNT);
  localparam int LINK_W  = BLK_W + 1;
  localparam int CNT_W   = $clog2(BLOCK_COUNT + 1);
  localparam int SLOT_W  = $clog2(FILE_SLOTS);
  localparam int ACT_W   = 2;
  localparam int STS_W   = 2;
  localparam int WORD_W  = 32;

  localparam int GRP_W   = 16;
  localparam int GRP_N   = FILE_SLOTS / GRP_W;
  localparam int GIDX_W  = $clog2(GRP_N);
  localparam int BIT_W   = $clog2(GRP_W);

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(BLOCK_COUNT);

  localparam logic [ACT_W-1:0] ACT_CREATE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

  localparam logic [STS_W-1:0] STS_OK       = 2'd0;
  localparam logic [STS_W-1:0] STS_NO_BLOCK = 2'd1;
  localparam logic [STS_W-1:0] STS_NO_SLOT  = 2'd2;
  localparam logic [STS_W-1:0] STS_UNUSED   = 2'd3;

  typedef struct packed {
    logic             take_item;
    logic             rd_issue;
    logic             create_commit;
    logic             pop_commit;
    logic             append_tail;
    logic             walk_start;
    logic             walk_step;
    logic             walk_end;
    logic             set_status;
    logic [STS_W-1:0] status_code;
    logic             out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             slot_used;
    logic             free_empty;
    logic             slot_found;
    logic             walk_go;
    logic             out_free;
  } dp_stat_t;

endpackage

>>> rtl/lba_intf.sv
// Item and result channel interfaces of the linked block allocator.
// Depends on lba_pkg for field widths.
interface lba_item_if;
  logic                         valid;
  logic                         ready;
  logic [lba_pkg::ACT_W-1:0]    action;
  logic [lba_pkg::SLOT_W-1:0]   file_index;
  logic signed [lba_pkg::WORD_W-1:0] data_word;

  modport source (output valid, action, file_index, data_word, input ready);
  modport sink   (input valid, action, file_index, data_word, output ready);
endinterface

interface lba_result_if;
  logic                         valid;
  logic                         ready;
  logic [lba_pkg::STS_W-1:0]    status;
  logic [lba_pkg::SLOT_W-1:0]   file_index_out;
  logic [lba_pkg::BLK_W-1:0]    block_index;
  logic [lba_pkg::CNT_W-1:0]    freed_count;

  modport source (output valid, status, file_index_out, block_index, freed_count, input ready);
  modport sink   (input valid, status, file_index_out, block_index, freed_count, output ready);
endinterface

>>> rtl/linked_block_allocator.sv
// Linked block allocator top level: joins lba_ctrl and lba_dp to the item and result channels.
// Depends on lba_pkg, lba_item_if, lba_result_if, lba_ctrl and lba_dp.
//
// item_i carries one action per beat: create a file, append data_word to file_index, or
// delete file_index. result_o returns exactly one beat per item: status, the slot, the
// block taken and the count of blocks freed. Items are handled one at a time.
// An accepted item passes ISSUE, then create goes through CREATE, append through POP and
// LINK, a failed append/delete or no-op straight to FIN, and delete through HEAD and WALK;
// each then waits in FIN for the result register. The next item is taken in the cycle
// after its result is loaded. The delete walk frees one block a cycle, bounded by the
// single read port of the link memory.
// Reset clears the free list head, the fill count of the link memory and the slot map;
// blocks at or above the fill count read as still linked in order, so no clearing pass runs
// and an item is taken in the first cycle after reset.
// If result_o stalls, the finished beat holds in the output register; the next item is
// accepted and worked on, and its result waits until the register frees.
module linked_block_allocator (
  input logic          clk_i,
  input logic          rst_ni,
  lba_item_if.sink     item_i,
  lba_result_if.source result_o
);

  lba_pkg::ctl_cmd_t cmd;
  lba_pkg::dp_stat_t stat;
  logic              in_ready;

  lba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_valid_i (item_i.valid),
    .in_ready_o (in_ready)
  );

  lba_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .action_i         (item_i.action),
    .file_index_i     (item_i.file_index),
    .data_word_i      (item_i.data_word),
    .out_valid_o      (result_o.valid),
    .out_ready_i      (result_o.ready),
    .status_o         (result_o.status),
    .file_index_out_o (result_o.file_index_out),
    .block_index_o    (result_o.block_index),
    .freed_count_o    (result_o.freed_count)
  );

  assign item_i.ready = in_ready;

endmodule

>>> rtl/lba_dp.sv
// Datapath: link, word, head and tail memories, free list head, slot map and result register.
// Driven by lba_ctrl through lba_pkg::ctl_cmd_t; depends on lba_pkg.
module lba_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lba_pkg::ctl_cmd_t            cmd_i,
  output lba_pkg::dp_stat_t            stat_o,
  input  logic [lba_pkg::ACT_W-1:0]    action_i,
  input  logic [lba_pkg::SLOT_W-1:0]   file_index_i,
  input  logic [lba_pkg::WORD_W-1:0]   data_word_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [lba_pkg::STS_W-1:0]    status_o,
  output logic [lba_pkg::SLOT_W-1:0]   file_index_out_o,
  output logic [lba_pkg::BLK_W-1:0]    block_index_o,
  output logic [lba_pkg::CNT_W-1:0]    freed_count_o
);

  logic [lba_pkg::LINK_W-1:0] link_mem [lba_pkg::BLOCK_COUNT];
  logic [lba_pkg::WORD_W-1:0] word_mem [lba_pkg::BLOCK_COUNT];
  logic [lba_pkg::BLK_W-1:0]  head_mem [lba_pkg::FILE_SLOTS];
  logic [lba_pkg::BLK_W-1:0]  tail_mem [lba_pkg::FILE_SLOTS];

  logic [lba_pkg::ACT_W-1:0]      act_q;
  logic [lba_pkg::SLOT_W-1:0]     slot_q;
  logic [lba_pkg::WORD_W-1:0]     word_q;
  logic [lba_pkg::STS_W-1:0]      sts_q;
  logic [lba_pkg::SLOT_W-1:0]     slot_out_q;
  logic [lba_pkg::BLK_W-1:0]      blk_q;
  logic [lba_pkg::CNT_W-1:0]      freed_q;
  logic [lba_pkg::LINK_W-1:0]     cur_q;
  logic [lba_pkg::LINK_W-1:0]     fh_q;
  logic [lba_pkg::LINK_W-1:0]     hw_q, hw_d;
  logic [lba_pkg::FILE_SLOTS-1:0] used_q;
  logic [lba_pkg::GRP_N-1:0]      grp_q;
  logic [lba_pkg::LINK_W-1:0]     link_ra_q;
  logic                           untouched_q;
  logic [lba_pkg::LINK_W-1:0]     link_raw_q;
  logic [lba_pkg::BLK_W-1:0]      head_rd_q;
  logic [lba_pkg::BLK_W-1:0]      tail_rd_q;

  logic                           out_valid_q;
  logic [lba_pkg::STS_W-1:0]      out_sts_q;
  logic [lba_pkg::SLOT_W-1:0]     out_slot_q;
  logic [lba_pkg::BLK_W-1:0]      out_blk_q;
  logic [lba_pkg::CNT_W-1:0]      out_freed_q;

  logic [lba_pkg::LINK_W-1:0]     link_rd;
  logic                           link_re;
  logic [lba_pkg::LINK_W-1:0]     link_ra;
  logic                           link_we;
  logic [lba_pkg::BLK_W-1:0]      link_wa;
  logic [lba_pkg::LINK_W-1:0]     link_wd;
  logic                           tail_we;
  logic [lba_pkg::SLOT_W-1:0]     tail_wa;
  logic [lba_pkg::BLK_W-1:0]      tail_wd;
  logic [lba_pkg::GIDX_W-1:0]     grp_sel;
  logic [lba_pkg::GRP_W-1:0]      grp_vec;
  logic [lba_pkg::BIT_W-1:0]      bit_sel;
  logic [lba_pkg::SLOT_W-1:0]     found;

  // untouched blocks at or above the fill count still hold their reset link i+1
  assign link_rd = untouched_q ? link_ra_q + lba_pkg::LINK_W'(1) : link_raw_q;

  always_comb begin
    link_re = cmd_i.rd_issue | cmd_i.walk_start | cmd_i.walk_step;
    link_ra = fh_q;
    if (cmd_i.walk_start) begin
      link_ra = {1'b0, head_rd_q};
    end else if (cmd_i.walk_step) begin
      link_ra = link_rd;
    end
  end

  always_comb begin
    link_we = cmd_i.pop_commit | cmd_i.append_tail | cmd_i.walk_step;
    link_wa = fh_q[lba_pkg::BLK_W-1:0];
    link_wd = lba_pkg::NULL_LINK;
    if (cmd_i.append_tail) begin
      link_wa = tail_rd_q;
      link_wd = {1'b0, blk_q};
    end else if (cmd_i.walk_step) begin
      link_wa = cur_q[lba_pkg::BLK_W-1:0];
      link_wd = fh_q;
    end
  end

  always_comb begin
    hw_d = hw_q;
    if (link_we && ({1'b0, link_wa} >= hw_q)) begin
      hw_d = {1'b0, link_wa} + lba_pkg::LINK_W'(1);
    end
  end

  always_comb begin
    tail_we = cmd_i.create_commit | cmd_i.append_tail;
    tail_wa = found;
    tail_wd = fh_q[lba_pkg::BLK_W-1:0];
    if (cmd_i.append_tail) begin
      tail_wa = slot_q;
      tail_wd = blk_q;
    end
  end

  // lowest unused slot: group flags registered at issue, then group and bit select
  always_comb begin
    grp_sel = '0;
    for (int g = lba_pkg::GRP_N - 1; g >= 0; g--) begin
      if (grp_q[g]) begin
        grp_sel = lba_pkg::GIDX_W'(g);
      end
    end
    grp_vec = ~used_q[{grp_sel, lba_pkg::BIT_W'(0)} +: lba_pkg::GRP_W];
    bit_sel = '0;
    for (int b = lba_pkg::GRP_W - 1; b >= 0; b--) begin
      if (grp_vec[b]) begin
        bit_sel = lba_pkg::BIT_W'(b);
      end
    end
    found = {grp_sel, bit_sel};
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (link_re) begin
      link_raw_q <= link_mem[link_ra[lba_pkg::BLK_W-1:0]];
      link_ra_q  <= link_ra;
      untouched_q <= (link_ra >= hw_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append_tail) begin
      word_mem[blk_q] <= word_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.create_commit) begin
      head_mem[found] <= fh_q[lba_pkg::BLK_W-1:0];
    end
    if (cmd_i.rd_issue) begin
      head_rd_q <= head_mem[slot_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail_we) begin
      tail_mem[tail_wa] <= tail_wd;
    end
    if (cmd_i.rd_issue) begin
      tail_rd_q <= tail_mem[slot_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fh_q   <= '0;
      hw_q   <= '0;
      used_q <= '0;
    end else begin
      hw_q <= hw_d;
      if (cmd_i.pop_commit) begin
        fh_q <= link_rd;
      end else if (cmd_i.walk_step) begin
        fh_q <= cur_q;
      end
      if (cmd_i.create_commit) begin
        used_q[found] <= 1'b1;
      end
      if (cmd_i.walk_end) begin
        used_q[slot_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      act_q      <= action_i;
      slot_q     <= file_index_i;
      word_q     <= data_word_i;
      sts_q      <= lba_pkg::STS_OK;
      slot_out_q <= file_index_i;
      blk_q      <= '0;
      freed_q    <= '0;
    end
    if (cmd_i.rd_issue) begin
      for (int g = 0; g < lba_pkg::GRP_N; g++) begin
        grp_q[g] <= ~&used_q[g*lba_pkg::GRP_W +: lba_pkg::GRP_W];
      end
    end
    if (cmd_i.set_status) begin
      sts_q <= cmd_i.status_code;
    end
    if (cmd_i.create_commit) begin
      slot_out_q <= found;
    end
    if (cmd_i.pop_commit) begin
      blk_q <= fh_q[lba_pkg::BLK_W-1:0];
    end
    if (cmd_i.walk_start) begin
      cur_q <= {1'b0, head_rd_q};
    end else if (cmd_i.walk_step) begin
      cur_q   <= link_rd;
      freed_q <= freed_q + lba_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_sts_q   <= sts_q;
      out_slot_q  <= slot_out_q;
      out_blk_q   <= blk_q;
      out_freed_q <= freed_q;
    end
  end

  assign stat_o.action     = act_q;
  assign stat_o.slot_used  = used_q[slot_q];
  assign stat_o.free_empty = (fh_q >= lba_pkg::NULL_LINK);
  assign stat_o.slot_found = |grp_q;
  assign stat_o.walk_go    = (cur_q < lba_pkg::NULL_LINK) &&
                             (freed_q < lba_pkg::CNT_W'(lba_pkg::BLOCK_COUNT));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_sts_q;
  assign file_index_out_o = out_slot_q;
  assign block_index_o    = out_blk_q;
  assign freed_count_o    = out_freed_q;

endmodule

>>> rtl/lba_ctrl.sv
// Controller state machine: sequences issue, create, append, delete walk and result load.
// Commands lba_dp through lba_pkg::ctl_cmd_t; depends on lba_pkg.
module lba_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lba_pkg::dp_stat_t  stat_i,
  output lba_pkg::ctl_cmd_t  cmd_o,
  input  logic               in_valid_i,
  output logic               in_ready_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ISSUE  = 3'd1;
  localparam logic [2:0] S_CREATE = 3'd2;
  localparam logic [2:0] S_POP    = 3'd3;
  localparam logic [2:0] S_LINK   = 3'd4;
  localparam logic [2:0] S_HEAD   = 3'd5;
  localparam logic [2:0] S_WALK   = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take_item = 1'b1;
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd_o.rd_issue = 1'b1;
        case (stat_i.action)
          lba_pkg::ACT_CREATE: begin
            state_d = S_CREATE;
          end
          lba_pkg::ACT_APPEND: begin
            if (!stat_i.slot_used) begin
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = lba_pkg::STS_UNUSED;
              state_d = S_FIN;
            end else if (stat_i.free_empty) begin
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = lba_pkg::STS_NO_BLOCK;
              state_d = S_FIN;
            end else begin
              state_d = S_POP;
            end
          end
          lba_pkg::ACT_DELETE: begin
            if (!stat_i.slot_used) begin
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = lba_pkg::STS_UNUSED;
              state_d = S_FIN;
            end else begin
              state_d = S_HEAD;
            end
          end
          default: begin
            state_d = S_FIN;
          end
        endcase
      end
      S_CREATE: begin
        if (!stat_i.slot_found) begin
          cmd_o.set_status  = 1'b1;
          cmd_o.status_code = lba_pkg::STS_NO_SLOT;
        end else if (stat_i.free_empty) begin
          cmd_o.set_status  = 1'b1;
          cmd_o.status_code = lba_pkg::STS_NO_BLOCK;
        end else begin
          cmd_o.create_commit = 1'b1;
          cmd_o.pop_commit    = 1'b1;
        end
        state_d = S_FIN;
      end
      S_POP: begin
        cmd_o.pop_commit = 1'b1;
        state_d = S_LINK;
      end
      S_LINK: begin
        cmd_o.append_tail = 1'b1;
        state_d = S_FIN;
      end
      S_HEAD: begin
        cmd_o.walk_start = 1'b1;
        state_d = S_WALK;
      end
      S_WALK: begin
        if (stat_i.walk_go) begin
          cmd_o.walk_step = 1'b1;
        end else begin
          cmd_o.walk_end = 1'b1;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

>>> tb/linked_block_allocator_tb.sv
`timescale 1ns / 100ps
// Testbench for linked_block_allocator: directed, exhaustion, backpressure and random tests.
// Depends on lba_pkg, lba_item_if, lba_result_if and the linked_block_allocator RTL.
module linked_block_allocator_tb;
  import lba_pkg::*;

  localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

  typedef struct packed {
    logic [STS_W-1:0]  status;
    logic [SLOT_W-1:0] slot;
    logic [BLK_W-1:0]  blk;
    logic [CNT_W-1:0]  freed;
  } outcome_t;

  logic clk;
  logic rst_n;

  lba_item_if   item_bus ();
  lba_result_if result_bus ();

  linked_block_allocator dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .item_i   (item_bus),
    .result_o (result_bus)
  );

  logic [LINK_W-1:0] next_link [BLOCK_COUNT];
  logic [LINK_W-1:0] chain_head [FILE_SLOTS];
  logic [LINK_W-1:0] chain_tail [FILE_SLOTS];
  logic [LINK_W-1:0] free_list_head;
  int                free_blocks;

  outcome_t pending_outcomes [$];
  int       fail_count = 0;
  int       send_gap_max;
  int       recv_gap_max;
  int       stall_left;
  int       hold_left;

  function automatic void reset_allocator_model();
    for (int i = 0; i < BLOCK_COUNT; i++) next_link[i] = LINK_W'(i + 1);
    for (int i = 0; i < FILE_SLOTS; i++) begin
      chain_head[i] = NULL_LINK;
      chain_tail[i] = NULL_LINK;
    end
    free_list_head = '0;
    free_blocks    = BLOCK_COUNT;
  endfunction

  function automatic bit take_free_block(output logic [BLK_W-1:0] blk);
    blk = '0;
    if (free_list_head >= NULL_LINK) return 1'b0;
    blk = free_list_head[BLK_W-1:0];
    free_list_head = next_link[blk];
    next_link[blk] = NULL_LINK;
    free_blocks--;
    return 1'b1;
  endfunction

  function automatic outcome_t apply_action(logic [ACT_W-1:0] act, logic [SLOT_W-1:0] idx);
    outcome_t          res;
    logic [BLK_W-1:0]  blk;
    logic [LINK_W-1:0] cur;
    logic [LINK_W-1:0] nxt;
    int                found;
    bit                used;
    res.status = STS_OK;
    res.slot   = idx;
    res.blk    = '0;
    res.freed  = '0;
    used  = chain_head[idx] < NULL_LINK;
    found = -1;
    case (act)
      ACT_CREATE: begin
        for (int i = 0; i < FILE_SLOTS && found < 0; i++) begin
          if (chain_head[i] >= NULL_LINK) found = i;
        end
        if (found < 0) begin
          res.status = STS_NO_SLOT;
        end else if (!take_free_block(blk)) begin
          res.status = STS_NO_BLOCK;
        end else begin
          chain_head[found] = {1'b0, blk};
          chain_tail[found] = {1'b0, blk};
          res.slot = SLOT_W'(found);
          res.blk  = blk;
        end
      end
      ACT_APPEND: begin
        if (!used) begin
          res.status = STS_UNUSED;
        end else if (!take_free_block(blk)) begin
          res.status = STS_NO_BLOCK;
        end else begin
          if (chain_tail[idx] < NULL_LINK) next_link[chain_tail[idx][BLK_W-1:0]] = {1'b0, blk};
          chain_tail[idx] = {1'b0, blk};
          res.blk = blk;
        end
      end
      ACT_DELETE: begin
        if (!used) begin
          res.status = STS_UNUSED;
        end else begin
          cur = chain_head[idx];
          while (cur < NULL_LINK && res.freed < CNT_W'(BLOCK_COUNT)) begin
            nxt = next_link[cur[BLK_W-1:0]];
            next_link[cur[BLK_W-1:0]] = free_list_head;
            free_list_head = cur;
            res.freed = res.freed + CNT_W'(1);
            free_blocks++;
            cur = nxt;
          end
          chain_head[idx] = NULL_LINK;
          chain_tail[idx] = NULL_LINK;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic int pick_used_slot();
    int cnt;
    int k;
    cnt = 0;
    for (int i = 0; i < FILE_SLOTS; i++) begin
      if (chain_head[i] < NULL_LINK) cnt++;
    end
    if (cnt == 0) return -1;
    k = $urandom_range(0, cnt - 1);
    for (int i = 0; i < FILE_SLOTS; i++) begin
      if (chain_head[i] < NULL_LINK) begin
        if (k == 0) return i;
        k--;
      end
    end
    return -1;
  endfunction

  task automatic send_item(input logic [ACT_W-1:0] act, input logic [SLOT_W-1:0] idx,
                           input logic [WORD_W-1:0] word);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_bus.valid      <= 1'b1;
    item_bus.action     <= act;
    item_bus.file_index <= idx;
    item_bus.data_word  <= word;
    do @(posedge clk); while (!item_bus.ready);
    pending_outcomes.push_back(apply_action(act, idx));
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    item_bus.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_gap_max = 3;
    recv_gap_max = 3;
    send_item(ACT_APPEND, 7'd0, 32'h0000_0001);
    send_item(ACT_DELETE, 7'd127, 32'h0);
    send_item(ACT_NOP, 7'd127, 32'hFFFF_FFFF);
    send_item(ACT_CREATE, 7'd127, 32'h0);
    send_item(ACT_APPEND, 7'd0, 32'h7FFF_FFFF);
    send_item(ACT_APPEND, 7'd0, 32'h8000_0000);
    send_item(ACT_APPEND, 7'd0, 32'h0000_0000);
    send_item(ACT_APPEND, 7'd0, 32'hFFFF_FFFF);
    send_item(ACT_CREATE, 7'd0, 32'h0);
    send_item(ACT_APPEND, 7'd1, 32'h5555_5555);
    send_item(ACT_APPEND, 7'd0, 32'hAAAA_AAAA);
    send_item(ACT_DELETE, 7'd0, 32'h0);
    send_item(ACT_CREATE, 7'd85, 32'h0);
    send_item(ACT_DELETE, 7'd1, 32'h0);
    send_item(ACT_DELETE, 7'd1, 32'h0);
    send_item(ACT_NOP, 7'd0, 32'h0);
    send_item(ACT_NOP, 7'd85, 32'h1234_5678);
    send_item(ACT_DELETE, 7'd0, 32'h0);
    wait_for_drain();
  endtask

  task automatic test_slot_exhaust();
    int slot;
    send_gap_max = 7;
    recv_gap_max = 7;
    repeat (FILE_SLOTS + 2) send_item(ACT_CREATE, SLOT_W'($urandom), $urandom);
    slot = pick_used_slot();
    while (slot >= 0) begin
      send_item(ACT_DELETE, SLOT_W'(slot), $urandom);
      slot = pick_used_slot();
    end
    wait_for_drain();
  endtask

  task automatic test_block_exhaust();
    int slot;
    send_gap_max = 0;
    recv_gap_max = 0;
    repeat (3) send_item(ACT_CREATE, SLOT_W'($urandom), $urandom);
    while (free_blocks > 0) send_item(ACT_APPEND, SLOT_W'(pick_used_slot()), $urandom);
    repeat (3) send_item(ACT_APPEND, SLOT_W'(pick_used_slot()), $urandom);
    repeat (2) send_item(ACT_CREATE, SLOT_W'($urandom), $urandom);
    slot = pick_used_slot();
    while (slot >= 0) begin
      send_item(ACT_DELETE, SLOT_W'(slot), $urandom);
      slot = pick_used_slot();
    end
    wait_for_drain();
  endtask

  task automatic test_backpressure();
    int slot;
    send_gap_max = 0;
    recv_gap_max = 3;
    send_item(ACT_CREATE, SLOT_W'($urandom), $urandom);
    hold_left = 400;
    slot = pick_used_slot();
    repeat (40) send_item(ACT_APPEND, SLOT_W'(slot), $urandom);
    send_item(ACT_DELETE, SLOT_W'(slot), $urandom);
    wait_for_drain();
  endtask

  task automatic test_random();
    int pick;
    int slot;
    for (int n = 0; n < 400; n++) begin
      if (n % 80 == 0) begin
        send_gap_max = $urandom_range(0, 1) * 7;
        recv_gap_max = $urandom_range(0, 1) * 7;
      end
      pick = $urandom_range(0, 99);
      slot = pick_used_slot();
      if (pick < 15 || slot < 0) begin
        send_item(ACT_CREATE, SLOT_W'($urandom), $urandom);
      end else if (pick < 70) begin
        send_item(ACT_APPEND, SLOT_W'(slot), $urandom);
      end else if (pick < 82) begin
        send_item(ACT_DELETE, SLOT_W'(slot), $urandom);
      end else if (pick < 90) begin
        send_item(ACT_W'($urandom_range(1, 2)), SLOT_W'($urandom), $urandom);
      end else if (pick < 95) begin
        send_item(ACT_NOP, SLOT_W'($urandom), $urandom);
      end else begin
        send_item(ACT_W'($urandom), SLOT_W'($urandom), $urandom);
      end
    end
    wait_for_drain();
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    result_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    outcome_t want;
    if (rst_n && result_bus.valid && result_bus.ready) begin
      stall_left = $urandom_range(0, recv_gap_max);
      if (pending_outcomes.size() == 0) begin
        $error("result beat with no outstanding item");
        fail_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (result_bus.status !== want.status) begin
          $error("field status expected %0d actual %0d", want.status, result_bus.status);
          fail_count++;
        end
        if (result_bus.file_index_out !== want.slot) begin
          $error("field file_index_out expected %0d actual %0d", want.slot,
                 result_bus.file_index_out);
          fail_count++;
        end
        if (result_bus.block_index !== want.blk) begin
          $error("field block_index expected %0d actual %0d", want.blk,
                 result_bus.block_index);
          fail_count++;
        end
        if (result_bus.freed_count !== want.freed) begin
          $error("field freed_count expected %0d actual %0d", want.freed,
                 result_bus.freed_count);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #(10_000_000);
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n               = 1'b0;
    item_bus.valid      = 1'b0;
    item_bus.action     = '0;
    item_bus.file_index = '0;
    item_bus.data_word  = '0;
    send_gap_max        = 0;
    recv_gap_max        = 0;
    stall_left          = 0;
    hold_left           = 0;
    reset_allocator_model();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_slot_exhaust();
    test_block_exhaust();
    test_backpressure();
    test_random();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && pending_outcomes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
